FILE: hw/rtl/dmh_pkg.sv
// Package for the d-ary min-heap task queue: word types and function codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dmh_pkg;
  localparam logic [2:0] FUNC_INSERT = 3'd0;
  localparam logic [2:0] FUNC_UPDATE = 3'd1;
  localparam logic [2:0] FUNC_DEL_TOP = 3'd2;
  localparam logic [2:0] FUNC_DEL_ID = 3'd3;
  localparam logic [2:0] FUNC_PEEK = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef struct packed {
    logic [2:0]         func;
    logic [15:0]        task_id;
    logic signed [31:0] deadline;
    logic [15:0]        priority_req;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               top_valid;
    logic [15:0]        top_id;
    logic signed [31:0] top_deadline;
    logic [15:0]        top_priority;
    logic [6:0]         entry_count;
  } rsp_t;

  typedef struct packed {
    logic [15:0]        id;
    logic signed [31:0] dl;
    logic [15:0]        pr;
  } slot_t;
endpackage
`default_nettype wire

FILE: hw/rtl/dary_min_heap_task_queue.sv
// Top level of the d-ary min-heap task queue: one slot memory and a sequencer.
// Depends on dmh_pkg.
`timescale 1ns / 1ps
`default_nettype none
// One word is taken when start_i is high and busy_o low. busy_o stays high through
// the result cycle, in which done_o marks the result for one cycle. The receiver
// cannot stall, so the result must be taken in that cycle. An insert climbs one
// level at a time; an id search reads the slots one by one; a removal moves the
// last slot into the hole and sifts it up or down, reading up to ARITY children
// per level. Then, or at once for peek and errors without a search, the top slot
// is read for the result. All slot traffic goes through one memory with one read
// or write port use per cycle and a registered read.
module dary_min_heap_task_queue #(
  parameter int CAPACITY = 64,
  parameter int ARITY = 4
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            start_i,
  input  dmh_pkg::req_t  req_i,
  output logic           busy_o,
  output logic           done_o,
  output dmh_pkg::rsp_t  rsp_o
);
  import dmh_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KW = $clog2(ARITY + 1);
  // parent index by reciprocal multiplication, exact for all AW-bit indexes
  localparam int PS = AW + KW;
  localparam int PW = 2 * AW + KW;
  localparam int PM = ((1 << PS) + ARITY - 1) / ARITY;

  typedef enum logic [3:0] {
    S_IDLE, S_FIND_RD, S_FIND_CHK, S_UP_RD, S_UP_CHK, S_DN_RD, S_DN_CHK,
    S_DN_WR, S_LAST_RD, S_LAST_GOT, S_PAR_CHK, S_TOP_RD, S_TOP_GOT, S_DONE
  } state_e;

  function automatic logic [AW-1:0] parent_of(logic [AW-1:0] x);
    logic [AW-1:0] xm1;
    logic [PW-1:0] prod;
    xm1 = x - AW'(1);
    prod = PW'(xm1) * PW'(PM);
    return prod[PS +: AW];
  endfunction

  slot_t mem [CAPACITY];
  slot_t rd_q;
  logic           we;
  logic [AW-1:0]  waddr, raddr;
  slot_t          wdata;
  logic           re;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rd_q <= mem[raddr];
  end

  state_e         state_q;
  req_t           req_q;
  slot_t          cur_q, best_q;
  logic [AW-1:0]  pos_q, best_pos_q, par_q;
  logic [CW-1:0]  cnt_q, idx_q;
  logic [KW-1:0]  k_q;
  logic [1:0]     status_q;
  logic           del_q;

  logic [CW+4:0]  child_w;
  always_comb child_w = (CW+5)'(pos_q) * (CW+5)'(ARITY) + (CW+5)'(k_q) + (CW+5)'(1);

  always_comb begin
    we = 1'b0; waddr = pos_q; wdata = cur_q; re = 1'b0; raddr = pos_q;
    case (state_q)
      S_IDLE: begin
        re = 1'b1; raddr = AW'(cnt_q - CW'(1));
      end
      S_FIND_RD: begin re = 1'b1; raddr = idx_q[AW-1:0]; end
      S_UP_RD: begin re = 1'b1; raddr = par_q; end
      S_UP_CHK: begin
        we = 1'b1;
        if (pos_q != '0 && cur_q.dl < rd_q.dl) begin
          wdata = rd_q;
        end
      end
      S_DN_RD: begin re = 1'b1; raddr = child_w[AW-1:0]; end
      S_DN_WR: begin
        we = 1'b1;
        if (best_pos_q != pos_q) wdata = best_q;
      end
      S_LAST_RD: begin re = 1'b1; raddr = cnt_q[AW-1:0]; end
      S_PAR_CHK: begin re = 1'b1; raddr = par_q; end
      S_TOP_RD: begin re = 1'b1; raddr = '0; end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      done_o <= 1'b0;
      rsp_o <= '0;
      status_q <= ST_OK;
    end else begin
      done_o <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            req_q <= req_i;
            status_q <= ST_OK;
            idx_q <= '0;
            cur_q <= '{id: req_i.task_id, dl: req_i.deadline, pr: req_i.priority_req};
            case (req_i.func)
              FUNC_INSERT: begin
                if (cnt_q >= CW'(CAPACITY)) begin
                  status_q <= ST_FULL; state_q <= S_TOP_RD;
                end else begin
                  pos_q <= cnt_q[AW-1:0];
                  par_q <= parent_of(cnt_q[AW-1:0]);
                  cnt_q <= cnt_q + CW'(1);
                  state_q <= S_UP_RD;
                end
              end
              FUNC_UPDATE, FUNC_DEL_ID: begin
                if (cnt_q == '0) begin
                  status_q <= ST_NOT_FOUND; state_q <= S_TOP_RD;
                end else state_q <= S_FIND_RD;
              end
              FUNC_DEL_TOP: begin
                if (cnt_q == '0) begin
                  status_q <= ST_EMPTY; state_q <= S_TOP_RD;
                end else begin
                  pos_q <= '0; cnt_q <= cnt_q - CW'(1);
                  state_q <= S_LAST_GOT;
                end
              end
              default: begin
                if (cnt_q == '0) status_q <= ST_EMPTY;
                state_q <= S_TOP_RD;
              end
            endcase
          end
        end
        S_FIND_RD: state_q <= S_FIND_CHK;
        S_FIND_CHK: begin
          if (rd_q.id == req_q.task_id) begin
            pos_q <= idx_q[AW-1:0];
            par_q <= parent_of(idx_q[AW-1:0]);
            if (req_q.func == FUNC_UPDATE) begin
              if (req_q.deadline < rd_q.dl) state_q <= S_UP_RD;
              else begin k_q <= '0; best_q <= cur_q; best_pos_q <= idx_q[AW-1:0];
                state_q <= S_DN_RD; end
            end else begin
              cnt_q <= cnt_q - CW'(1);
              state_q <= S_LAST_RD;
            end
          end else if (idx_q + CW'(1) >= cnt_q) begin
            status_q <= ST_NOT_FOUND; state_q <= S_TOP_RD;
          end else begin
            idx_q <= idx_q + CW'(1); state_q <= S_FIND_RD;
          end
        end
        S_LAST_RD: state_q <= S_LAST_GOT;
        S_LAST_GOT: begin
          // rd_q holds the last slot; cnt_q already reduced
          cur_q <= rd_q;
          if (CW'(pos_q) >= cnt_q) state_q <= S_TOP_RD;
          else if (pos_q == '0) begin
            k_q <= '0; best_q <= rd_q; best_pos_q <= pos_q; state_q <= S_DN_RD;
          end else state_q <= S_PAR_CHK;
        end
        S_PAR_CHK: state_q <= S_UP_CHK;
        S_UP_RD: state_q <= S_UP_CHK;
        S_UP_CHK: begin
          if (pos_q != '0 && cur_q.dl < rd_q.dl) begin
            pos_q <= par_q;
            par_q <= parent_of(par_q);
            state_q <= S_UP_RD;
          end else if (req_q.func == FUNC_DEL_ID && pos_q == '0) begin
            state_q <= S_TOP_RD;
          end else if (req_q.func == FUNC_DEL_ID && !del_q) begin
            k_q <= '0; best_q <= cur_q; best_pos_q <= pos_q; state_q <= S_DN_RD;
          end else state_q <= S_TOP_RD;
        end
        S_DN_RD: begin
          if (k_q == KW'(ARITY) || child_w >= (CW+5)'(cnt_q)) state_q <= S_DN_WR;
          else state_q <= S_DN_CHK;
        end
        S_DN_CHK: begin
          if (rd_q.dl < best_q.dl) begin
            best_q <= rd_q; best_pos_q <= AW'(child_w - (CW+5)'(0));
          end
          k_q <= k_q + KW'(1);
          state_q <= S_DN_RD;
        end
        S_DN_WR: begin
          if (best_pos_q != pos_q) begin
            pos_q <= best_pos_q; best_pos_q <= best_pos_q; best_q <= cur_q;
            k_q <= '0; state_q <= S_DN_RD;
          end else state_q <= S_TOP_RD;
        end
        S_TOP_RD: state_q <= S_TOP_GOT;
        S_TOP_GOT: begin
          done_o <= 1'b1;
          rsp_o.status <= status_q;
          rsp_o.entry_count <= 7'(cnt_q);
          rsp_o.top_valid <= cnt_q != '0;
          rsp_o.top_id <= (cnt_q != '0) ? rd_q.id : '0;
          rsp_o.top_deadline <= (cnt_q != '0) ? rd_q.dl : '0;
          rsp_o.top_priority <= (cnt_q != '0) ? rd_q.pr : '0;
          state_q <= S_DONE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // del_q marks that sift up moved a slot; only a delete-by-id refill reads it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) del_q <= 1'b0;
    else if (state_q == S_IDLE) del_q <= 1'b0;
    else if (state_q == S_UP_CHK && pos_q != '0 && cur_q.dl < rd_q.dl) del_q <= 1'b1;
  end

  assign busy_o = state_q != S_IDLE;
endmodule
`default_nettype wire

FILE: sim/dary_min_heap_task_queue_checker.sv
// Checker for the d-ary min-heap task queue: mirrors the heap on accepted words
// and compares each done_o word with the predicted one. Depends on dmh_pkg.
`timescale 1ns / 1ps
module dary_min_heap_task_queue_checker #(
  parameter int CAPACITY = 64,
  parameter int ARITY = 4
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           start_i,
  input  wire           busy_i,
  input  dmh_pkg::req_t req_i,
  input  wire           done_i,
  input  dmh_pkg::rsp_t rsp_i,
  output int            fail_count_o,
  output int            pending_o
);
  import dmh_pkg::*;

  slot_t       heap_q[CAPACITY];
  int          heap_n;
  rsp_t        expected_rsp_q[$];

  function automatic bit earlier(int a, int b);
    return heap_q[a].dl < heap_q[b].dl;
  endfunction

  function automatic void swap_slots(int a, int b);
    slot_t t;
    t = heap_q[a];
    heap_q[a] = heap_q[b];
    heap_q[b] = t;
  endfunction

  function automatic void climb(int i);
    int p;
    while (i > 0) begin
      p = (i - 1) / ARITY;
      if (!earlier(i, p)) break;
      swap_slots(i, p);
      i = p;
    end
  endfunction

  function automatic void sink(int i);
    int best;
    int c;
    forever begin
      best = i;
      for (int k = 0; k < ARITY; k++) begin
        c = ARITY * i + k + 1;
        if (c < heap_n && earlier(c, best)) best = c;
      end
      if (best == i) break;
      swap_slots(i, best);
      i = best;
    end
  endfunction

  function automatic int find_task(logic [15:0] id);
    for (int i = 0; i < heap_n; i++) if (heap_q[i].id == id) return i;
    return -1;
  endfunction

  function automatic void remove_slot(int i);
    heap_q[i] = heap_q[heap_n - 1];
    heap_n--;
    if (i < heap_n) begin
      if (i > 0 && earlier(i, (i - 1) / ARITY)) climb(i);
      else sink(i);
    end
  endfunction

  function automatic rsp_t apply_word(req_t w);
    rsp_t r;
    int i;
    logic signed [31:0] old_dl;
    r = '0;
    r.status = ST_OK;
    case (w.func)
      FUNC_INSERT: begin
        if (heap_n >= CAPACITY) r.status = ST_FULL;
        else begin
          heap_q[heap_n] = '{id: w.task_id, dl: w.deadline, pr: w.priority_req};
          heap_n++;
          climb(heap_n - 1);
        end
      end
      FUNC_UPDATE: begin
        i = find_task(w.task_id);
        if (i < 0) r.status = ST_NOT_FOUND;
        else begin
          old_dl = heap_q[i].dl;
          heap_q[i] = '{id: w.task_id, dl: w.deadline, pr: w.priority_req};
          if (w.deadline < old_dl) climb(i);
          else sink(i);
        end
      end
      FUNC_DEL_TOP: begin
        if (heap_n == 0) r.status = ST_EMPTY;
        else remove_slot(0);
      end
      FUNC_DEL_ID: begin
        i = find_task(w.task_id);
        if (i < 0) r.status = ST_NOT_FOUND;
        else remove_slot(i);
      end
      default: if (heap_n == 0) r.status = ST_EMPTY;
    endcase
    if (heap_n > 0) begin
      r.top_valid = 1'b1;
      r.top_id = heap_q[0].id;
      r.top_deadline = heap_q[0].dl;
      r.top_priority = heap_q[0].pr;
    end
    r.entry_count = 7'(heap_n);
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    pending_o = 0;
    heap_n = 0;
  end

  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni) begin
      if (done_i) begin
        if (expected_rsp_q.size() == 0)
          report("unexpected word", 64'(rsp_i.top_id), 64'(0));
        else begin
          e = expected_rsp_q.pop_front();
          if (rsp_i.status !== e.status)
            report("status", 64'(rsp_i.status), 64'(e.status));
          if (rsp_i.top_valid !== e.top_valid)
            report("top_valid", 64'(rsp_i.top_valid), 64'(e.top_valid));
          if (rsp_i.top_id !== e.top_id)
            report("top_id", 64'(rsp_i.top_id), 64'(e.top_id));
          if (rsp_i.top_deadline !== e.top_deadline)
            report("top_deadline", 64'(rsp_i.top_deadline), 64'(e.top_deadline));
          if (rsp_i.top_priority !== e.top_priority)
            report("top_priority", 64'(rsp_i.top_priority), 64'(e.top_priority));
          if (rsp_i.entry_count !== e.entry_count)
            report("entry_count", 64'(rsp_i.entry_count), 64'(e.entry_count));
        end
      end
      if (start_i && !busy_i) expected_rsp_q = {expected_rsp_q, apply_word(req_i)};
      pending_o = expected_rsp_q.size();
    end
  end
endmodule

FILE: sim/dary_min_heap_task_queue_tb.sv
// Testbench top for the d-ary min-heap task queue: drives directed and random
// words and gives the verdict. Depends on dmh_pkg, the queue and the checker module.
`timescale 1ns / 1ps
module dary_min_heap_task_queue_tb;
  import dmh_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  req_t req_i = '0;
  logic busy_o;
  logic done_o;
  rsp_t rsp_o;
  int   fail_count;
  int   pending;
  int   idle_pct;
  int   held;
  logic [15:0] used_ids[$];

  always #5 clk_i = ~clk_i;

  dary_min_heap_task_queue DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .req_i(req_i),
    .busy_o(busy_o), .done_o(done_o), .rsp_o(rsp_o)
  );

  dary_min_heap_task_queue_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_i(busy_o),
    .req_i(req_i), .done_i(done_o), .rsp_i(rsp_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  task automatic send(logic [2:0] f, logic [15:0] id, logic [31:0] dl, logic [15:0] pr);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
    start_i <= 1'b1;
    req_i <= '{func: f, task_id: id, deadline: dl, priority_req: pr};
    @(negedge clk_i);
    start_i <= 1'b0;
    if (f == FUNC_INSERT && held < 64) begin
      held++;
      used_ids = {used_ids, id};
    end
  endtask

  function automatic logic [31:0] rand_dl();
    case ($urandom_range(3))
      0: return $urandom_range(15) - 8;
      1: return {$urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFF0} + $urandom_range(15);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_id();
    if (used_ids.size() > 0 && $urandom_range(3) != 0)
      return used_ids[$urandom_range(used_ids.size() - 1)];
    return 16'($urandom_range(65535));
  endfunction

  task automatic random_word();
    int r;
    logic [2:0] f;
    r = $urandom_range(99);
    if (r < 40) f = FUNC_INSERT;
    else if (r < 60) f = FUNC_UPDATE;
    else if (r < 75) f = FUNC_DEL_TOP;
    else if (r < 90) f = FUNC_DEL_ID;
    else f = 3'($urandom_range(4, 7));
    send(f, pick_id(), rand_dl(), 16'($urandom_range(65535)));
    if (f == FUNC_DEL_TOP || f == FUNC_DEL_ID) held = checker_i.heap_n;
  endtask

  initial begin
    idle_pct = 0;
    held = 0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send(FUNC_PEEK, 0, 0, 0);
    send(FUNC_DEL_TOP, 0, 0, 0);
    send(FUNC_UPDATE, 16'h1234, 0, 0);
    send(FUNC_DEL_ID, 16'h1234, 0, 0);
    send(3'd7, 0, 0, 0);
    send(FUNC_INSERT, 16'hFFFF, 32'h7FFF_FFFF, 16'hFFFF);
    send(FUNC_INSERT, 16'h0000, 32'h8000_0000, 16'h0000);
    send(FUNC_INSERT, 16'h0005, 32'h0000_0000, 16'h00AA);
    send(FUNC_INSERT, 16'h0005, 32'h0000_0000, 16'h0055);
    send(FUNC_UPDATE, 16'h0005, 32'hFFFF_FFFF, 16'h1111);
    send(FUNC_UPDATE, 16'h0000, 32'h7FFF_FFFF, 16'h2222);
    send(FUNC_DEL_ID, 16'hFFFF, 0, 0);
    send(3'd5, 0, 0, 0);
    send(3'd6, 0, 0, 0);
    send(FUNC_DEL_TOP, 0, 0, 0);
    held = checker_i.heap_n;
    for (int i = 0; i < 64; i++) send(FUNC_INSERT, 16'(i), rand_dl(), 16'(i));
    send(FUNC_INSERT, 16'hABCD, 0, 0);
    held = checker_i.heap_n;
    while (held > 0) begin
      send(FUNC_DEL_TOP, 0, 0, 0);
      held = checker_i.heap_n;
    end
    used_ids.delete();
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 88 : (ph == 3) ? 17 : 0;
      for (int n = 0; n < 220; n++) random_word();
    end
    while (pending > 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule

FILE: sim.f
hw/rtl/dmh_pkg.sv
hw/rtl/dary_min_heap_task_queue.sv
sim/dary_min_heap_task_queue_checker.sv
sim/dary_min_heap_task_queue_tb.sv
